// ===== src/sysex_pkg.sv =====
package sysex_pkg;

    // fixed framing of the 7-bit form
    localparam int GROUP_SIZE = 7;
    localparam int CMD_BYTES  = GROUP_SIZE + 1;
    localparam int FILL_W     = $clog2(GROUP_SIZE + 1);
    localparam int CNT_W      = $clog2(CMD_BYTES + 1);
    localparam int IDX_W      = $clog2(CMD_BYTES);
    localparam int COUNT_W    = 16;

    localparam logic [7:0] HIGH_BIT = 8'h80;
    localparam logic [7:0] LOW_MASK = 8'h7F;

    // register indexes on the configuration port
    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_MAX_OUTPUT = 1'b1;

    typedef enum logic
    {
        MODE_PACK   = 1'b0,
        MODE_UNPACK = 1'b1
    } mode_t;

    // one command from the front end: a run of bytes, then an optional summary
    typedef struct packed
    {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      eob;
        logic [COUNT_W-1:0]        total;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/sysex_front.sv =====
module sysex_front
    import sysex_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                cfg_fire,
    input  logic                cfg_index,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  q_status_t           q_stat,
    output logic                push,
    output cmd_t                push_cmd
);

    mode_t                      mode_reg, mode_next;
    logic [COUNT_W-1:0]         max_out_reg, max_out_next;
    logic [GROUP_SIZE-1:0][7:0] store_reg, store_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [7:0]                 hb_reg, hb_next;
    logic [COUNT_W-1:0]         cnt_reg, cnt_next;
    logic                       stop_reg, stop_next;

    logic                       in_fire;
    logic [FILL_W-1:0]          fill_idx;
    logic [FILL_W-1:0]          fill_inc;
    logic [7:0]                 hb_new;
    logic [COUNT_W:0]           grp_end;

    assign in_ready = !q_stat.full;
    assign in_fire  = in_valid && in_ready;

    // classify the item and update the buffer state
    always_comb
    begin
        mode_next    = mode_reg;
        max_out_next = max_out_reg;
        store_next   = store_reg;
        fill_next    = fill_reg;
        hb_next      = hb_reg;
        cnt_next     = cnt_reg;
        stop_next    = stop_reg;
        push_cmd     = '0;
        fill_idx     = (fill_reg == FILL_W'(GROUP_SIZE)) ? '0 : fill_reg;
        fill_inc     = fill_idx + FILL_W'(1);
        hb_new       = hb_reg | (in_byte[7] ? (8'd1 << fill_idx) : 8'd0);
        grp_end      = {1'b0, cnt_reg} + (COUNT_W + 1)'(fill_inc) + (COUNT_W + 1)'(1);

        if (in_fire)
        begin
            unique case (mode_reg)
                MODE_PACK:
                begin
                    store_next[fill_idx] = in_byte;
                    fill_next            = fill_inc;
                    hb_next              = hb_new;
                    if (fill_inc == FILL_W'(GROUP_SIZE) || in_last)
                    begin
                        if (!stop_reg)
                        begin
                            if (grp_end > {1'b0, max_out_reg})
                            begin
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                push_cmd.bytes[0] = hb_new;
                                for (int k = 0; k < GROUP_SIZE; k++)
                                begin
                                    push_cmd.bytes[k+1] = store_next[k] & LOW_MASK;
                                end
                                push_cmd.count = CNT_W'(fill_inc) + CNT_W'(1);
                                cnt_next       = grp_end[COUNT_W-1:0];
                            end
                        end
                        fill_next = '0;
                        hb_next   = '0;
                    end
                end
                MODE_UNPACK:
                begin
                    if (fill_reg == '0)
                    begin
                        hb_next   = in_byte;
                        fill_next = FILL_W'(1);
                    end
                    else
                    begin
                        if (!stop_reg)
                        begin
                            if (cnt_reg >= max_out_reg)
                            begin
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                push_cmd.bytes[0] = in_byte |
                                    (hb_reg[FILL_W'(fill_reg - FILL_W'(1))] ? HIGH_BIT : 8'd0);
                                push_cmd.count = CNT_W'(1);
                                cnt_next       = cnt_reg + COUNT_W'(1);
                            end
                        end
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                default:
                begin
                    fill_next = '0;
                end
            endcase

            // end of buffer: summary and fresh state
            if (in_last)
            begin
                push_cmd.eob   = 1'b1;
                push_cmd.total = cnt_next;
                fill_next      = '0;
                hb_next        = '0;
                cnt_next       = '0;
                stop_next      = 1'b0;
            end
        end

        // register writes
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_MODE:
                begin
                    mode_next = mode_t'(cfg_data[0]);
                    fill_next = '0;
                    hb_next   = '0;
                    cnt_next  = '0;
                    stop_next = 1'b0;
                end
                REG_MAX_OUTPUT:
                begin
                    max_out_next = cfg_data;
                end
                default:
                begin
                    max_out_next = max_out_reg;
                end
            endcase
        end
    end

    assign push = in_fire && (push_cmd.count != '0 || push_cmd.eob);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_PACK;
            max_out_reg <= '1;
            fill_reg    <= '0;
            hb_reg      <= '0;
            cnt_reg     <= '0;
            stop_reg    <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            max_out_reg <= max_out_next;
            fill_reg    <= fill_next;
            hb_reg      <= hb_next;
            cnt_reg     <= cnt_next;
            stop_reg    <= stop_next;
        end
    end

    // group bytes
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    // a pack group never holds more than a full group between items
    a_pack_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PACK) |-> (fill_reg < FILL_W'(GROUP_SIZE)))
        else $error("pack group fill out of range");

endmodule

// ===== src/sysex_cmdq.sv =====
module sysex_cmdq
    import sysex_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    assign stat.full  = (lvl_reg == LVL_W'(DEPTH));
    assign stat.empty = (lvl_reg == '0);
    assign head       = entry_reg[rd_reg];

    // pointer and level update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        lvl_next = lvl_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            lvl_next = lvl_reg + LVL_W'(1);
        end
        else if (pop && !push)
        begin
            lvl_next = lvl_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("command queue underflow");

endmodule

// ===== src/sysex_back.sv =====
module sysex_back
    import sysex_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               head,
    input  q_status_t          q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_is_data,
    output logic [COUNT_W-1:0] out_total,
    output logic               out_eob
);

    logic               valid_reg, valid_next;
    logic [7:0]         byte_reg, byte_next;
    logic               data_reg, data_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               eob_reg, eob_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               load;

    assign load = !valid_reg || out_ready;

    // walk the head command one item a cycle while the output register can load
    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        data_next  = data_reg;
        total_next = total_reg;
        eob_next   = eob_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (q_stat.empty)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                valid_next = 1'b1;
                if (idx_reg < head.count)
                begin
                    byte_next  = head.bytes[idx_reg[IDX_W-1:0]];
                    data_next  = 1'b1;
                    total_next = '0;
                    eob_next   = 1'b0;
                    if ((idx_reg + CNT_W'(1)) == head.count && !head.eob)
                    begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    byte_next  = '0;
                    data_next  = 1'b0;
                    total_next = head.total;
                    eob_next   = 1'b1;
                    pop        = 1'b1;
                    idx_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        data_reg  <= data_next;
        total_reg <= total_next;
        eob_reg   <= eob_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_is_data = data_reg;
    assign out_total   = total_reg;
    assign out_eob     = eob_reg;

    // the walk position never passes the head command
    a_idx_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty |-> (idx_reg <= head.count))
        else $error("byte index beyond command");

endmodule

// ===== src/sysex_7bit_pack_unpack.sv =====
// MIDI SysEx 7-bit packer and unpacker.
// Input item on s_axis: tdata = data byte, tlast = last byte of the buffer.
// Result item on m_axis: tdata = out byte and total count, tuser = 1 for a
// data byte, tlast = 1 on the end-of-buffer summary that closes each buffer.
// Registers on the cfg channel: index 0 mode (0 pack, 1 unpack), index 1
// max_output. cfg_ready is always high; write only while the block is idle.
// Writing mode drops any buffer in progress.
// The front end classifies one item per cycle while the queue has room, and
// posts byte runs into a short command queue; the back end sends one result
// item per cycle from its output register unless the receiver stalls. Each
// result passes through a queue entry, then the output register. Unpack
// takes an item every cycle unless the receiver stalls; pack emits 8 bytes
// per group of 7 inputs, held back by the single-byte output port, and each buffer adds a summary item.
// If the receiver stalls the queue fills and s_axis_tready drops; nothing
// is lost. Reset empties the queue, selects pack mode, sets max_output to
// 65535 and clears the buffer state; there is no clearing pass.
module sysex_7bit_pack_unpack
    import sysex_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [7:0] out_byte, [23:8] total_count
    output logic         m_axis_tuser,   // [0] is_data
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    q_status_t          q_stat;
    cmd_t               push_cmd;
    cmd_t               head;
    logic               push;
    logic               pop;
    logic [7:0]         out_byte;
    logic [COUNT_W-1:0] out_total;

    assign cfg_ready = 1'b1;

    sysex_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    sysex_cmdq #(.DEPTH(QUEUE_DEPTH)) u_cmdq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    sysex_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (out_byte),
        .out_is_data (m_axis_tuser),
        .out_total   (out_total),
        .out_eob     (m_axis_tlast)
    );

    assign m_axis_tdata = {out_total, out_byte};

endmodule
